// ----- src/bdlp_pkg.sv -----
`timescale 1ns / 1ps
package bdlp_pkg;

  localparam int NOW_W      = 32;
  localparam int TIME_CFG_W = 16;
  localparam int CFG_ADDR_W = 2;
  localparam int CFG_DATA_W = 16;
  localparam int CMDQ_DEPTH = 2;
  localparam int CMDQ_PW    = 1;
  localparam int CMDQ_CW    = 2;

  localparam logic MODE_POLL  = 1'b0;
  localparam logic REQ_NOTIFY = 1'b1;

  localparam logic [TIME_CFG_W-1:0] DEBOUNCE_RST = 16'd20;
  localparam logic [TIME_CFG_W-1:0] LONG_RST     = 16'd1000;

  typedef enum logic [CFG_ADDR_W-1:0] {
    CFG_MODE     = 2'd0,
    CFG_LEVEL    = 2'd1,
    CFG_DEBOUNCE = 2'd2,
    CFG_LONG     = 2'd3
  } cfg_idx_t;

  typedef enum logic [1:0] {
    K_UPDATE_POLL  = 2'd0,
    K_UPDATE_DRAIN = 2'd1,
    K_NOTIFY       = 2'd2,
    K_ERROR        = 2'd3
  } kind_t;

  typedef enum logic [2:0] {
    B_IDLE,
    B_DISPATCH,
    B_RD,
    B_DRAIN,
    B_COMMIT,
    B_LONG,
    B_RESULT
  } bst_t;

  typedef struct packed {
    logic                  mode;
    logic                  press_pol;
    logic [TIME_CFG_W-1:0] debounce;
    logic [TIME_CFG_W-1:0] long_press;
  } cfg_t;

  typedef struct packed {
    kind_t             kind;
    logic              lvl;
    logic [NOW_W-1:0]  now;
  } cmd_t;

  typedef struct packed {
    logic             raw;
    logic             stable;
    logic [2:0]       edges;
    logic             long_flag;
    logic             long_rep;
    logic             cand_valid;
    logic             cand_level;
    logic [NOW_W-1:0] cand_time;
    logic [NOW_W-1:0] press_time;
  } dbst_t;

  typedef struct packed {
    logic status;
    logic raw_level_pressed;
    logic stable_pressed;
    logic press_edge;
    logic release_edge;
    logic long_held;
    logic long_edge;
  } res_t;

  function automatic dbst_t db_commit(dbst_t s, logic [NOW_W-1:0] ref_t,
                                      logic [TIME_CFG_W-1:0] deb);
    dbst_t            r;
    logic [NOW_W-1:0] elapsed;
    r       = s;
    elapsed = ref_t - s.cand_time;
    if (s.cand_valid) begin
      if (s.cand_level == s.stable) begin
        r.cand_valid = 1'b0;
      end else if (elapsed >= {{(NOW_W-TIME_CFG_W){1'b0}}, deb}) begin
        r.stable     = s.cand_level;
        r.cand_valid = 1'b0;
        r.long_flag  = 1'b0;
        r.long_rep   = 1'b0;
        if (s.cand_level) begin
          r.edges[0]   = 1'b1;
          r.press_time = s.cand_time + {{(NOW_W-TIME_CFG_W){1'b0}}, deb};
        end else begin
          r.edges[1]   = 1'b1;
          r.press_time = '0;
        end
      end
    end
    return r;
  endfunction

  function automatic dbst_t db_sample(dbst_t s, logic lvl, logic [NOW_W-1:0] t);
    dbst_t r;
    r     = s;
    r.raw = lvl;
    if (lvl == s.stable) begin
      r.cand_valid = 1'b0;
    end else if (!s.cand_valid || s.cand_level != lvl) begin
      r.cand_level = lvl;
      r.cand_time  = t;
      r.cand_valid = 1'b1;
    end
    return r;
  endfunction

  function automatic dbst_t db_long(dbst_t s, logic [NOW_W-1:0] now,
                                    logic [TIME_CFG_W-1:0] lp);
    dbst_t            r;
    logic [NOW_W-1:0] held;
    r    = s;
    held = now - s.press_time;
    if (s.stable && !s.long_rep && held >= {{(NOW_W-TIME_CFG_W){1'b0}}, lp}) begin
      r.long_flag = 1'b1;
      r.edges[2]  = 1'b1;
      r.long_rep  = 1'b1;
    end
    return r;
  endfunction

endpackage

// ----- src/button_debounce_long_press.sv -----
`timescale 1ns / 1ps
// Button debouncer with long-press detection. Each input transfer is an update
// (in_tuser = 0) or a pin-change notification (in_tuser = 1) carrying a raw pin
// level and a millisecond timestamp; every transfer yields exactly one result.
// A front stage classifies transfers into a two-entry command queue; a back-end
// sequencer executes them one at a time against the debounce state and the
// QUEUE_DEPTH-entry sample memory. A notification or error goes straight to
// the result; a polling update passes commit and long-press check first; an
// interrupt-mode update also first drains queued samples (one memory read and
// one commit/sample step per entry). Throughput is bounded by the back-end
// sequencer. Configuration must be written through cfg_we/cfg_addr/cfg_wdata
// only while the block is idle (not enforced); no clearing pass after reset.
module button_debounce_long_press import bdlp_pkg::*; #(
  parameter int QUEUE_DEPTH = 8
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  cfg_we,
  input  logic [CFG_ADDR_W-1:0] cfg_addr,
  input  logic [CFG_DATA_W-1:0] cfg_wdata,
  input  logic                  in_tvalid,
  output logic                  in_tready,
  input  logic [39:0]           in_tdata,   // pin_level, now_ms[31:0], zero pad
  input  logic                  in_tuser,   // req_type
  output logic                  out_tvalid,
  input  logic                  out_tready,
  output logic [7:0]            out_tdata,  // raw_level_pressed, stable_pressed,
                                            // press_edge, release_edge,
                                            // long_held, long_edge, zero pad
  output logic                  out_tuser   // status
);

  cfg_t cfg_r, cfg_nxt;
  logic push_valid, push_ready, pop_valid, pop;
  cmd_t push_cmd, pop_cmd;
  res_t res;

  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_we) begin
      unique case (cfg_idx_t'(cfg_addr))
        CFG_MODE:     cfg_nxt.mode       = cfg_wdata[0];
        CFG_LEVEL:    cfg_nxt.press_pol  = cfg_wdata[0];
        CFG_DEBOUNCE: cfg_nxt.debounce   = cfg_wdata[TIME_CFG_W-1:0];
        CFG_LONG:     cfg_nxt.long_press = cfg_wdata[TIME_CFG_W-1:0];
        default:      cfg_nxt = cfg_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.mode       <= MODE_POLL;
      cfg_r.press_pol  <= 1'b0;
      cfg_r.debounce   <= DEBOUNCE_RST;
      cfg_r.long_press <= LONG_RST;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  bdlp_front u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg        (cfg_r),
    .in_valid   (in_tvalid),
    .in_ready   (in_tready),
    .req_type   (in_tuser),
    .pin_level  (in_tdata[0]),
    .now_ms     (in_tdata[NOW_W:1]),
    .push_valid (push_valid),
    .push_cmd   (push_cmd),
    .push_ready (push_ready)
  );

  bdlp_cmdq u_cmdq (
    .clk        (clk),
    .rst_n      (rst_n),
    .push_valid (push_valid),
    .push_cmd   (push_cmd),
    .push_ready (push_ready),
    .pop_valid  (pop_valid),
    .pop_cmd    (pop_cmd),
    .pop        (pop)
  );

  bdlp_back #(
    .QUEUE_DEPTH (QUEUE_DEPTH)
  ) u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg       (cfg_r),
    .cmd_valid (pop_valid),
    .cmd       (pop_cmd),
    .cmd_pop   (pop),
    .out_valid (out_tvalid),
    .res       (res),
    .out_ready (out_tready)
  );

  assign out_tuser = res.status;
  assign out_tdata = {2'b00, res.long_edge, res.long_held, res.release_edge,
                      res.press_edge, res.stable_pressed, res.raw_level_pressed};

  a_long_edge_held: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tdata[5] |-> out_tdata[4] && out_tdata[1])
    else $error("long press edge without long held and stable press");

  a_reset_quiet: assert property (@(posedge clk)
    !rst_n |=> !out_tvalid)
    else $error("result valid right after reset");

  a_no_pop_when_empty: assert property (@(posedge clk) disable iff (!rst_n)
    pop |-> pop_valid)
    else $error("command popped from empty queue");

endmodule

// ----- src/bdlp_front.sv -----
`timescale 1ns / 1ps
module bdlp_front import bdlp_pkg::*; (
  input  logic             clk,
  input  logic             rst_n,
  input  cfg_t             cfg,
  input  logic             in_valid,
  output logic             in_ready,
  input  logic             req_type,
  input  logic             pin_level,
  input  logic [NOW_W-1:0] now_ms,
  output logic             push_valid,
  output cmd_t             push_cmd,
  input  logic             push_ready
);

  logic  fr_valid_r, fr_valid_nxt;
  cmd_t  fr_cmd_r, fr_cmd_nxt;
  kind_t kind;
  logic  in_acc;

  assign in_ready = !fr_valid_r || push_ready;
  assign in_acc   = in_valid && in_ready;

  always_comb begin
    if (req_type == REQ_NOTIFY) begin
      kind = (cfg.mode == MODE_POLL) ? K_ERROR : K_NOTIFY;
    end else begin
      kind = (cfg.mode == MODE_POLL) ? K_UPDATE_POLL : K_UPDATE_DRAIN;
    end
  end

  always_comb begin
    fr_cmd_nxt   = fr_cmd_r;
    fr_valid_nxt = fr_valid_r && !push_ready;
    if (in_acc) begin
      fr_valid_nxt    = 1'b1;
      fr_cmd_nxt.kind = kind;
      fr_cmd_nxt.lvl  = (pin_level == cfg.press_pol);
      fr_cmd_nxt.now  = now_ms;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fr_valid_r <= 1'b0;
    end else begin
      fr_valid_r <= fr_valid_nxt;
    end
    fr_cmd_r <= fr_cmd_nxt;
  end

  assign push_valid = fr_valid_r;
  assign push_cmd   = fr_cmd_r;

endmodule

// ----- src/bdlp_cmdq.sv -----
`timescale 1ns / 1ps
module bdlp_cmdq import bdlp_pkg::*; (
  input  logic clk,
  input  logic rst_n,
  input  logic push_valid,
  input  cmd_t push_cmd,
  output logic push_ready,
  output logic pop_valid,
  output cmd_t pop_cmd,
  input  logic pop
);

  cmd_t               q_r [CMDQ_DEPTH];
  logic [CMDQ_PW-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [CMDQ_PW-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [CMDQ_CW-1:0] cnt_r, cnt_nxt;
  logic               do_push, do_pop;

  assign push_ready = (cnt_r != CMDQ_CW'(CMDQ_DEPTH));
  assign pop_valid  = (cnt_r != '0);
  assign pop_cmd    = q_r[rd_ptr_r];
  assign do_push    = push_valid && push_ready;
  assign do_pop     = pop && pop_valid;

  always_comb begin
    wr_ptr_nxt = do_push ? wr_ptr_r + 1'b1 : wr_ptr_r;
    rd_ptr_nxt = do_pop ? rd_ptr_r + 1'b1 : rd_ptr_r;
    cnt_nxt    = cnt_r;
    if (do_push && !do_pop) begin
      cnt_nxt = cnt_r + 1'b1;
    end else if (!do_push && do_pop) begin
      cnt_nxt = cnt_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      q_r[wr_ptr_r] <= push_cmd;
    end
  end

endmodule

// ----- src/bdlp_back.sv -----
`timescale 1ns / 1ps
module bdlp_back import bdlp_pkg::*; #(
  parameter int QUEUE_DEPTH = 8
) (
  input  logic clk,
  input  logic rst_n,
  input  cfg_t cfg,
  input  logic cmd_valid,
  input  cmd_t cmd,
  output logic cmd_pop,
  output logic out_valid,
  output res_t res,
  input  logic out_ready
);

  localparam int QW      = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int CW      = $clog2(QUEUE_DEPTH + 1);
  localparam int ENTRY_W = NOW_W + 1;

  bst_t             bst_r, bst_nxt;
  dbst_t            st_r, st_nxt;
  cmd_t             cur_r, cur_nxt;
  logic             stat_r, stat_nxt;
  logic [QW-1:0]    head_r, head_nxt, tail_r, tail_nxt;
  logic [QW-1:0]    head_inc, tail_inc;
  logic [CW-1:0]    cnt_r, cnt_nxt;
  logic             sq_we;
  logic [ENTRY_W-1:0] sq_mem [QUEUE_DEPTH];
  logic [ENTRY_W-1:0] sq_rd_r;
  logic             out_valid_r, out_valid_nxt;
  res_t             res_r, res_nxt;
  logic             out_free;
  dbst_t            st_clr;

  assign out_free = !out_valid_r || out_ready;
  assign head_inc = (head_r == QW'(QUEUE_DEPTH - 1)) ? '0 : head_r + 1'b1;
  assign tail_inc = (tail_r == QW'(QUEUE_DEPTH - 1)) ? '0 : tail_r + 1'b1;

  always_comb begin
    st_clr       = st_r;
    st_clr.edges = '0;
  end

  always_comb begin
    bst_nxt = bst_r;
    unique case (bst_r)
      B_IDLE: begin
        if (cmd_valid) begin
          bst_nxt = B_DISPATCH;
        end
      end
      B_DISPATCH: begin
        unique case (cur_r.kind)
          K_ERROR, K_NOTIFY: bst_nxt = B_RESULT;
          K_UPDATE_POLL:     bst_nxt = B_COMMIT;
          K_UPDATE_DRAIN:    bst_nxt = (cnt_r != '0) ? B_RD : B_COMMIT;
          default:           bst_nxt = B_RESULT;
        endcase
      end
      B_RD:     bst_nxt = B_DRAIN;
      B_DRAIN:  bst_nxt = (cnt_r > CW'(1)) ? B_RD : B_COMMIT;
      B_COMMIT: bst_nxt = B_LONG;
      B_LONG:   bst_nxt = B_RESULT;
      B_RESULT: begin
        if (out_free) begin
          bst_nxt = B_IDLE;
        end
      end
      default:  bst_nxt = B_IDLE;
    endcase
  end

  always_comb begin
    st_nxt        = st_r;
    cur_nxt       = cur_r;
    stat_nxt      = stat_r;
    head_nxt      = head_r;
    tail_nxt      = tail_r;
    cnt_nxt       = cnt_r;
    sq_we         = 1'b0;
    cmd_pop       = 1'b0;
    res_nxt       = res_r;
    out_valid_nxt = out_valid_r && !out_ready;
    unique case (bst_r)
      B_IDLE: begin
        if (cmd_valid) begin
          cmd_pop = 1'b1;
          cur_nxt = cmd;
        end
      end
      B_DISPATCH: begin
        stat_nxt = 1'b0;
        unique case (cur_r.kind)
          K_ERROR: stat_nxt = 1'b1;
          K_NOTIFY: begin
            st_nxt.raw = cur_r.lvl;
            if (cur_r.lvl != st_r.raw) begin
              sq_we    = 1'b1;
              tail_nxt = tail_inc;
              if (cnt_r == CW'(QUEUE_DEPTH)) begin
                head_nxt = head_inc;
              end else begin
                cnt_nxt = cnt_r + 1'b1;
              end
            end
          end
          K_UPDATE_POLL:  st_nxt = db_sample(st_clr, cur_r.lvl, cur_r.now);
          K_UPDATE_DRAIN: st_nxt = st_clr;
          default:        st_nxt = st_r;
        endcase
      end
      B_DRAIN: begin
        st_nxt   = db_sample(db_commit(st_r, sq_rd_r[NOW_W-1:0], cfg.debounce),
                             sq_rd_r[NOW_W], sq_rd_r[NOW_W-1:0]);
        head_nxt = head_inc;
        cnt_nxt  = cnt_r - 1'b1;
      end
      B_COMMIT: st_nxt = db_commit(st_r, cur_r.now, cfg.debounce);
      B_LONG:   st_nxt = db_long(st_r, cur_r.now, cfg.long_press);
      B_RESULT: begin
        if (out_free) begin
          out_valid_nxt             = 1'b1;
          res_nxt.status            = stat_r;
          res_nxt.raw_level_pressed = st_r.raw;
          res_nxt.stable_pressed    = st_r.stable;
          res_nxt.press_edge        = st_r.edges[0];
          res_nxt.release_edge      = st_r.edges[1];
          res_nxt.long_held         = st_r.long_flag;
          res_nxt.long_edge         = st_r.edges[2];
        end
      end
      default: st_nxt = st_r;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      bst_r       <= B_IDLE;
      st_r        <= '0;
      head_r      <= '0;
      tail_r      <= '0;
      cnt_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      bst_r       <= bst_nxt;
      st_r        <= st_nxt;
      head_r      <= head_nxt;
      tail_r      <= tail_nxt;
      cnt_r       <= cnt_nxt;
      out_valid_r <= out_valid_nxt;
    end
    cur_r  <= cur_nxt;
    stat_r <= stat_nxt;
    res_r  <= res_nxt;
  end

  always_ff @(posedge clk) begin
    if (sq_we) begin
      sq_mem[tail_r] <= {cur_r.lvl, cur_r.now};
    end
  end

  always_ff @(posedge clk) begin
    if (bst_r == B_RD) begin
      sq_rd_r <= sq_mem[head_r];
    end
  end

  assign out_valid = out_valid_r;
  assign res       = res_r;

endmodule
